FILE: design/hdf_pkg.sv
// ----------------------------------------------------------------------------
// hdf_pkg
// Types, codes and helpers shared by the HTTP/2 frame deframer modules.
// ----------------------------------------------------------------------------
package hdf_pkg;

  localparam int QueueDepthDefault = 4;

  localparam logic [3:0] HDR_LEN = 4'd9;
  localparam logic [3:0] HDR_LAST = 4'd8;

  localparam int FLAG_PADDED_BIT = 3;
  localparam int FLAG_PRIORITY_BIT = 5;
  localparam int FLAG_END_HEADERS_BIT = 2;
  localparam int FLAG_ACK_BIT = 0;

  localparam logic [23:0] FIXED_LEN = 24'd4;
  localparam logic [23:0] GOAWAY_MIN = 24'd8;

  localparam logic [7:0] T_DATA = 8'd0;
  localparam logic [7:0] T_HEADERS = 8'd1;
  localparam logic [7:0] T_RST = 8'd3;
  localparam logic [7:0] T_SETTINGS = 8'd4;
  localparam logic [7:0] T_PUSH = 8'd5;
  localparam logic [7:0] T_GOAWAY = 8'd7;
  localparam logic [7:0] T_WINDOW = 8'd8;
  localparam logic [7:0] T_CONT = 8'd9;

  localparam logic [3:0] ERR_SET_IN_BLOCK = 4'd0;
  localparam logic [3:0] ERR_SET_ON_STREAM = 4'd1;
  localparam logic [3:0] ERR_SET_ACK_LEN = 4'd2;
  localparam logic [3:0] ERR_DATA_IN_BLOCK = 4'd3;
  localparam logic [3:0] ERR_DATA_STREAM0 = 4'd4;
  localparam logic [3:0] ERR_WIN_IN_BLOCK = 4'd5;
  localparam logic [3:0] ERR_SIZE = 4'd6;
  localparam logic [3:0] ERR_RST_ID_ZERO = 4'd7;
  localparam logic [3:0] ERR_HDR_IN_BLOCK = 4'd8;
  localparam logic [3:0] ERR_HDR_STREAM0 = 4'd9;
  localparam logic [3:0] ERR_PUSH_IN_BLOCK = 4'd10;
  localparam logic [3:0] ERR_PUSH_STREAM0 = 4'd11;
  localparam logic [3:0] ERR_CONT_NO_BLOCK = 4'd12;
  localparam logic [3:0] ERR_GOAWAY_STREAM = 4'd13;
  localparam logic [3:0] ERR_UNKNOWN = 4'd14;

  localparam logic [2:0] SET_PAIR_LAST = 3'd5;

  typedef enum logic [1:0] {
    REC_PAYLOAD = 2'd0,
    REC_SETTING = 2'd1,
    REC_DONE    = 2'd2,
    REC_ERROR   = 2'd3
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t   kind;
    logic [3:0]  ftype;
    logic [31:0] stream;
    logic [7:0]  flags;
    logic [7:0]  pbyte;
    logic [31:0] v1;
    logic [31:0] v2;
    logic [3:0]  code;
    logic        last;
  } rec_t;

  // Up to two records caused by one input byte.
  typedef struct packed {
    logic [1:0] cnt;
    rec_t       r1;
    rec_t       r0;
  } bundle_t;

  function automatic rec_t mk_rec(rec_kind_t k, logic [7:0] ty, logic [31:0] st,
                                  logic [7:0] fl, logic [7:0] by, logic [31:0] a,
                                  logic [31:0] c, logic [3:0] fc);
    rec_t r;
    r.kind = k;
    r.ftype = ty[3:0];
    r.stream = st;
    r.flags = fl;
    r.pbyte = by;
    r.v1 = a;
    r.v2 = c;
    r.code = fc;
    r.last = 1'b0;
    return r;
  endfunction

  // Bytes ahead of the fragment: pad length, priority, promised id.
  function automatic logic [2:0] lead_len(logic [7:0] ty, logic [7:0] fl);
    logic [2:0] pad;
    pad = {2'b00, fl[FLAG_PADDED_BIT]};
    if (ty == T_DATA) return pad;
    if (ty == T_HEADERS) return pad + (fl[FLAG_PRIORITY_BIT] ? 3'd5 : 3'd0);
    if (ty == T_PUSH) return pad + 3'd4;
    return 3'd0;
  endfunction

  // x mod 6 for x below 512: reciprocal multiply, exact in that range.
  function automatic logic [2:0] mod6(logic [8:0] x);
    logic [16:0] prod;
    logic [8:0] q;
    logic [8:0] r;
    prod = 17'(x) * 17'd171;
    q = {2'b00, prod[16:10]};
    r = x - 9'(q * 9'd6);
    return r[2:0];
  endfunction

endpackage

FILE: design/hdf_front.sv
// ----------------------------------------------------------------------------
// hdf_front
// Header collection, frame checks, payload walk; one byte per cycle on take.
// ----------------------------------------------------------------------------
module hdf_front import hdf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_byte,
  output bundle_t    bundle,
  output logic       halted
);

  logic [3:0]  hc, hc_next;
  logic [23:0] flen, flen_next;
  logic [7:0]  ftype, ftype_next;
  logic [7:0]  fflags, fflags_next;
  logic [31:0] fstream, fstream_next;
  logic [23:0] pc, pc_next;
  logic [7:0]  pad, pad_next;
  logic [63:0] acc, acc_next;
  logic        pend, pend_next;
  logic [31:0] pstream, pstream_next;
  logic        halted_next;
  logic [2:0]  lmod, lmod_next;
  logic [2:0]  sph, sph_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      hc <= '0; flen <= '0; ftype <= '0; fflags <= '0; fstream <= '0;
      pc <= '0; pad <= '0; acc <= '0; pend <= 1'b0; pstream <= '0;
      halted <= 1'b0; lmod <= '0; sph <= '0;
    end else begin
      hc <= hc_next; flen <= flen_next; ftype <= ftype_next;
      fflags <= fflags_next; fstream <= fstream_next; pc <= pc_next;
      pad <= pad_next; acc <= acc_next; pend <= pend_next;
      pstream <= pstream_next; halted <= halted_next; lmod <= lmod_next;
      sph <= sph_next;
    end
  end

  always_comb begin
    rec_t        recs [2];
    logic [1:0]  cnt;
    logic        fin;
    logic        failed;
    logic        cv;
    logic [3:0]  code;
    logic        z;
    logic [23:0] lead;
    logic [23:0] b24;
    logic [31:0] st;
    logic [31:0] v1;
    logic [31:0] v2;
    logic        dataish;

    hc_next = hc; flen_next = flen; ftype_next = ftype; fflags_next = fflags;
    fstream_next = fstream; pc_next = pc; pad_next = pad; acc_next = acc;
    pend_next = pend; pstream_next = pstream; halted_next = halted;
    lmod_next = lmod; sph_next = sph;
    recs[0] = '0; recs[1] = '0;
    cnt = 2'd0; fin = 1'b0; failed = 1'b0; cv = 1'b0; code = '0;
    b24 = {16'd0, in_byte};
    z = 1'b0; lead = '0; st = '0; v1 = '0; v2 = '0; dataish = 1'b0;

    if (take && !halted) begin
      if (hc != HDR_LEN) begin
        case (hc)
          4'd0: begin
            flen_next = b24;
            lmod_next = mod6({1'b0, in_byte});
          end
          4'd1, 4'd2: begin
            flen_next = {flen[15:0], in_byte};
            lmod_next = mod6({4'd0, lmod, 2'b00} + {1'b0, in_byte});
          end
          4'd3: ftype_next = in_byte;
          4'd4: fflags_next = in_byte;
          4'd5: fstream_next = {24'd0, in_byte};
          default: fstream_next = {fstream[23:0], in_byte};
        endcase
        if (hc != HDR_LAST) begin
          hc_next = hc + 4'd1;
        end else begin
          pc_next = '0; pad_next = '0; acc_next = '0; sph_next = '0;
          z = (fstream_next == 32'd0);
          lead = {21'd0, lead_len(ftype_next, fflags_next)};
          cv = 1'b1;
          case (ftype_next)
            T_SETTINGS: begin
              if (pend) code = ERR_SET_IN_BLOCK;
              else if (!z) code = ERR_SET_ON_STREAM;
              else if (fflags_next[FLAG_ACK_BIT] && flen_next != 24'd0) code = ERR_SET_ACK_LEN;
              else if (lmod_next != 3'd0) code = ERR_SIZE;
              else cv = 1'b0;
            end
            T_DATA: begin
              if (pend) code = ERR_DATA_IN_BLOCK;
              else if (z) code = ERR_DATA_STREAM0;
              else if (flen_next < lead) code = ERR_SIZE;
              else cv = 1'b0;
            end
            T_WINDOW: begin
              if (pend) code = ERR_WIN_IN_BLOCK;
              else if (flen_next != FIXED_LEN) code = ERR_SIZE;
              else cv = 1'b0;
            end
            T_RST: begin
              if (flen_next != FIXED_LEN) code = ERR_SIZE;
              else if (z) code = ERR_RST_ID_ZERO;
              else cv = 1'b0;
            end
            T_HEADERS: begin
              if (pend) code = ERR_HDR_IN_BLOCK;
              else if (z) code = ERR_HDR_STREAM0;
              else if (flen_next < lead) code = ERR_SIZE;
              else cv = 1'b0;
            end
            T_PUSH: begin
              if (pend) code = ERR_PUSH_IN_BLOCK;
              else if (z) code = ERR_PUSH_STREAM0;
              else if (flen_next < lead) code = ERR_SIZE;
              else cv = 1'b0;
            end
            T_CONT: begin
              if (!pend) code = ERR_CONT_NO_BLOCK;
              else cv = 1'b0;
            end
            T_GOAWAY: begin
              if (!z) code = ERR_GOAWAY_STREAM;
              else if (flen_next < GOAWAY_MIN) code = ERR_SIZE;
              else cv = 1'b0;
            end
            default: code = ERR_UNKNOWN;
          endcase
          if (cv) begin
            failed = 1'b1;
          end else if (flen_next == 24'd0) begin
            fin = 1'b1;
          end else begin
            hc_next = HDR_LEN;
          end
        end
      end else begin
        // Payload walk.
        lead = {21'd0, lead_len(ftype, fflags)};
        dataish = (ftype == T_DATA) || (ftype == T_HEADERS) || (ftype == T_PUSH);
        if (dataish) begin
          if (fflags[FLAG_PADDED_BIT] && pc == 24'd0) begin
            pad_next = in_byte;
            if (b24 > flen - lead) begin
              failed = 1'b1;
              code = ERR_SIZE;
            end
          end else if (pc < lead) begin
            if (ftype == T_PUSH && (pc + 24'd4 >= lead)) acc_next = {acc[55:0], in_byte};
          end else if (pc < flen - {16'd0, pad}) begin
            recs[0] = mk_rec(REC_PAYLOAD, ftype, fstream, fflags, in_byte, '0, '0, '0);
            cnt = 2'd1;
          end
        end else if (ftype == T_CONT) begin
          recs[0] = mk_rec(REC_PAYLOAD, ftype, pstream, fflags, in_byte, '0, '0, '0);
          cnt = 2'd1;
        end else if (ftype == T_SETTINGS) begin
          acc_next = {acc[55:0], in_byte};
          if (sph == SET_PAIR_LAST) begin
            recs[0] = mk_rec(REC_SETTING, ftype, fstream, fflags, 8'd0,
                             {16'd0, acc_next[47:32]}, acc_next[31:0], '0);
            cnt = 2'd1;
            acc_next = '0;
            sph_next = '0;
          end else begin
            sph_next = sph + 3'd1;
          end
        end else if (pc < 24'd8) begin
          acc_next = {acc[55:0], in_byte};
        end
        if (!failed) begin
          pc_next = pc + 24'd1;
          if (pc_next == flen) fin = 1'b1;
        end
      end

      if (failed) begin
        recs[0] = mk_rec(REC_ERROR, ftype_next, fstream_next, fflags_next, 8'd0,
                         '0, '0, code);
        cnt = 2'd1;
        halted_next = 1'b1;
        hc_next = '0;
      end

      if (fin) begin
        st = fstream_next;
        case (ftype_next)
          T_WINDOW, T_RST, T_PUSH: v1 = acc_next[31:0];
          T_GOAWAY: begin
            v1 = acc_next[63:32];
            v2 = acc_next[31:0];
          end
          T_CONT: st = pstream;
          default: ;
        endcase
        recs[cnt[0]] = mk_rec(REC_DONE, ftype_next, st, fflags_next, 8'd0, v1, v2, '0);
        cnt = cnt + 2'd1;
        if (ftype_next == T_HEADERS || ftype_next == T_PUSH) begin
          if (!fflags_next[FLAG_END_HEADERS_BIT]) begin
            pend_next = 1'b1;
            pstream_next = fstream_next;
          end
        end else if (ftype_next == T_CONT && fflags_next[FLAG_END_HEADERS_BIT]) begin
          pend_next = 1'b0;
        end
        hc_next = '0;
      end

      if (cnt != 2'd0) recs[cnt[1]].last = 1'b1;
    end

    bundle.cnt = cnt;
    bundle.r0 = recs[0];
    bundle.r1 = recs[1];
  end

endmodule

FILE: design/hdf_queue.sv
// ----------------------------------------------------------------------------
// hdf_queue
// Small register queue of record bundles between front and back.
// ----------------------------------------------------------------------------
module hdf_queue import hdf_pkg::*; #(
  parameter int DEPTH = QueueDepthDefault
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t wr_data,
  input  logic    pop,
  output bundle_t rd_data,
  output logic    full,
  output logic    empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

FILE: design/hdf_back.sv
// ----------------------------------------------------------------------------
// hdf_back
// Serialize each queued bundle into one or two output records.
// ----------------------------------------------------------------------------
module hdf_back import hdf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  bundle_t head,
  input  logic    empty,
  input  logic    out_ready,
  output logic    out_valid,
  output rec_t    rec,
  output logic    pop
);

  logic sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) sel <= 1'b0;
    else sel <= sel_next;
  end

  assign out_valid = !empty;
  assign rec = sel ? head.r1 : head.r0;

  always_comb begin
    pop = 1'b0;
    sel_next = sel;
    if (out_valid && out_ready) begin
      if (sel || head.cnt == 2'd1) begin
        pop = 1'b1;
        sel_next = 1'b0;
      end else begin
        sel_next = 1'b1;
      end
    end
  end

endmodule

FILE: design/http2_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// http2_frame_deframer_top
// HTTP/2 frame deframer: bytes in, payload/settings/done/error records out.
// ----------------------------------------------------------------------------
// The block takes one byte of an HTTP/2 frame stream per cycle on the slave
// stream side and emits records on the master side. Every byte is classified
// in the cycle it is accepted (header collection, frame checks, padding and
// priority skipping, field decode) and causes zero, one or two records: a
// payload byte, a SETTINGS pair, a frame-done record, or an error. The bundle
// goes into a short queue (QUEUE_DEPTH entries) and the back end plays it out
// one record per cycle while m_tready is high; a byte is taken every cycle
// while the queue has room. Two-record bytes (final payload byte or SETTINGS
// pair plus frame-done) go out as two records. Bundles are registered in the
// queue. An error record halts the block: later bytes are still accepted but
// dropped until reset. tlast marks the last record caused by one byte.
// ----------------------------------------------------------------------------
module http2_frame_deframer_top import hdf_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] in_byte
  output logic         m_tvalid,
  input  logic         m_tready,
  // [3:0] frame_kind, [35:4] stream_ident, [43:36] flag_bits,
  // [51:44] payload_byte, [83:52] value_first, [115:84] value_second,
  // [119:116] fault_code
  output logic [119:0] m_tdata,
  output logic [1:0]   m_tuser,   // [1:0] record_kind
  output logic         m_tlast    // last_of_run
);

  bundle_t front_bundle;
  bundle_t q_head;
  logic    halted;
  logic    take;
  logic    q_push, q_pop, q_full, q_empty;
  rec_t    rec;

  // Accept whenever the queue has room.
  assign s_tready = !q_full;
  assign take = s_tvalid && s_tready;
  assign q_push = take && (front_bundle.cnt != 2'd0);

  hdf_front u_front (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_byte (s_tdata),
    .bundle  (front_bundle),
    .halted  (halted)
  );

  hdf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (front_bundle),
    .pop     (q_pop),
    .rd_data (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  hdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .rec       (rec),
    .pop       (q_pop)
  );

  assign m_tdata = {rec.code, rec.v2, rec.v1, rec.pbyte, rec.flags, rec.stream, rec.ftype};
  assign m_tuser = rec.kind;
  assign m_tlast = rec.last;

  // An error record always ends its run.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == REC_ERROR) |-> m_tlast)
    else $error("error record without tlast");

  // Nothing is queued once halted.
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    halted |-> !q_push)
    else $error("record produced while halted");

  // Output valid exactly when the queue holds a bundle.
  a_valid_queue: assert property (@(posedge clk) disable iff (rst)
    m_tvalid == !q_empty)
    else $error("output valid out of step with queue");

endmodule
